// ----- hw/rtl/mpct_pkg.sv -----
// Shared types and constants for the mouse packet cursor tracker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mpct_pkg;

  localparam int GRID_COLS_DEF = 80;
  localparam int GRID_ROWS_DEF = 25;
  localparam int QUEUE_DEPTH   = 2;

  localparam int COL_PORT_W  = 7;
  localparam int ROW_PORT_W  = 5;
  localparam int ADDR_PORT_W = 12;

  localparam int ST_LEFT  = 0;
  localparam int ST_RIGHT = 1;
  localparam int ST_XSIGN = 4;
  localparam int ST_YSIGN = 5;
  localparam int ST_XOVF  = 6;
  localparam int ST_YOVF  = 7;

  typedef enum logic [1:0] {
    SEL_NONE    = 2'd0,
    SEL_PRESS   = 2'd1,
    SEL_DRAG    = 2'd2,
    SEL_RELEASE = 2'd3
  } sel_t;

  typedef struct packed {
    logic ovf;
    logic left;
    logic right;
    logic x_move;
    logic x_dec;
    logic y_move;
    logic y_dec;
  } pkt_t;

  typedef struct packed {
    logic                   overflow;
    logic                   left_down;
    logic                   right_down;
    logic [COL_PORT_W-1:0]  cursor_col;
    logic [ROW_PORT_W-1:0]  cursor_row;
    logic [ADDR_PORT_W-1:0] cell_address;
    sel_t                   select_event;
    logic [COL_PORT_W-1:0]  anchor_col;
    logic [ROW_PORT_W-1:0]  anchor_row;
    logic [COL_PORT_W-1:0]  corner_col;
    logic [ROW_PORT_W-1:0]  corner_row;
    logic                   paste_request;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mpct_queue.sv -----
// Small first-in first-out queue with registered entries.
// Generic; takes its default depth from mpct_pkg.
`default_nettype none

module mpct_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mpct_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mpct_front.sv -----
// Front end: gathers mouse bytes into packets and classifies each packet.
// Depends on mpct_pkg.
`default_nettype none

module mpct_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [7:0]         data_byte,
  output logic               full,
  output logic               pkt_push,
  output mpct_pkg::pkt_t     pkt,
  input  logic               pkt_full
);

  import mpct_pkg::*;

  typedef enum logic [1:0] {
    IDX_STATUS = 2'd0,
    IDX_XDELTA = 2'd1,
    IDX_YDELTA = 2'd2
  } idx_t;

  idx_t       byte_index;
  logic [7:0] status_byte;
  logic       x_move;
  logic       accept;

  assign full     = pkt_full && (byte_index == IDX_YDELTA);
  assign accept   = push && !full;
  assign pkt_push = accept && (byte_index == IDX_YDELTA);

  assign pkt.ovf    = status_byte[ST_XOVF] | status_byte[ST_YOVF];
  assign pkt.left   = status_byte[ST_LEFT];
  assign pkt.right  = status_byte[ST_RIGHT];
  assign pkt.x_move = x_move;
  assign pkt.x_dec  = status_byte[ST_XSIGN];
  assign pkt.y_move = |data_byte;
  assign pkt.y_dec  = !status_byte[ST_YSIGN];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= IDX_STATUS;
    end else if (accept) begin
      unique case (byte_index)
        IDX_XDELTA: byte_index <= IDX_YDELTA;
        IDX_YDELTA: byte_index <= IDX_STATUS;
        default:    byte_index <= IDX_XDELTA;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_index == IDX_XDELTA) begin
      x_move <= |data_byte;
    end
    if (accept && byte_index != IDX_XDELTA && byte_index != IDX_YDELTA) begin
      status_byte <= data_byte;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mpct_back.sv -----
// Back end: applies one packet to buttons, cursor and selection state.
// Depends on mpct_pkg.
`default_nettype none

module mpct_back #(
  parameter int GRID_COLS = mpct_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = mpct_pkg::GRID_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pkt_empty,
  input  mpct_pkg::pkt_t pkt,
  output logic           pkt_pop,
  input  logic           res_full,
  output logic           res_push,
  output mpct_pkg::res_t res
);

  import mpct_pkg::*;

  localparam int CW      = $clog2(GRID_COLS);
  localparam int RW      = $clog2(GRID_ROWS);
  localparam int CELLS_W = $clog2(GRID_COLS * GRID_ROWS);
  localparam int AW      = (CELLS_W + 1 > ADDR_PORT_W) ? CELLS_W + 1 : ADDR_PORT_W;
  localparam logic [CW-1:0] COL_MAX = CW'(GRID_COLS - 1);
  localparam logic [RW-1:0] ROW_MAX = RW'(GRID_ROWS - 1);

  logic          left_held;
  logic          right_held;
  logic [CW-1:0] pos_col;
  logic [RW-1:0] pos_row;
  logic [CW-1:0] start_col;
  logic [RW-1:0] start_row;

  logic          left_next;
  logic          right_next;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] step_col;
  logic [RW-1:0] step_row;
  logic [AW-1:0] cell_sum;
  logic          go;

  assign go       = !pkt_empty && !res_full;
  assign pkt_pop  = go;
  assign res_push = go;

  always_comb begin
    step_col = pos_col;
    if (pkt.x_move) begin
      if (pkt.x_dec) begin
        step_col = (pos_col == '0) ? '0 : pos_col - 1'b1;
      end else begin
        step_col = (pos_col >= COL_MAX) ? COL_MAX : pos_col + 1'b1;
      end
    end
    step_row = pos_row;
    if (pkt.y_move) begin
      if (pkt.y_dec) begin
        step_row = (pos_row == '0) ? '0 : pos_row - 1'b1;
      end else begin
        step_row = (pos_row >= ROW_MAX) ? ROW_MAX : pos_row + 1'b1;
      end
    end
  end

  assign left_next  = pkt.ovf ? left_held  : pkt.left;
  assign right_next = pkt.ovf ? right_held : pkt.right;
  assign col_next   = pkt.ovf ? pos_col    : step_col;
  assign row_next   = pkt.ovf ? pos_row    : step_row;
  assign cell_sum   = AW'(col_next) + AW'(row_next) * AW'(GRID_COLS);

  always_comb begin
    res               = '0;
    res.overflow      = pkt.ovf;
    res.left_down     = left_next;
    res.right_down    = right_next;
    res.cursor_col    = COL_PORT_W'(col_next);
    res.cursor_row    = ROW_PORT_W'(row_next);
    res.cell_address  = ADDR_PORT_W'({cell_sum[AW-2:0], 1'b1});
    res.paste_request = right_next && !right_held;
    if (left_next && !left_held) begin
      res.select_event = SEL_PRESS;
      res.anchor_col   = COL_PORT_W'(col_next);
      res.anchor_row   = ROW_PORT_W'(row_next);
      res.corner_col   = COL_PORT_W'(col_next);
      res.corner_row   = ROW_PORT_W'(row_next);
    end else if (left_next || left_held) begin
      res.select_event = left_next ? SEL_DRAG : SEL_RELEASE;
      res.anchor_col   = COL_PORT_W'(start_col);
      res.anchor_row   = ROW_PORT_W'(start_row);
      res.corner_col   = COL_PORT_W'(col_next);
      res.corner_row   = ROW_PORT_W'(row_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_held  <= 1'b0;
      right_held <= 1'b0;
      pos_col    <= '0;
      pos_row    <= '0;
      start_col  <= '0;
      start_row  <= '0;
    end else if (go) begin
      left_held  <= left_next;
      right_held <= right_next;
      pos_col    <= col_next;
      pos_row    <= row_next;
      if (left_next && !left_held) begin
        start_col <= col_next;
        start_row <= row_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mouse_packet_cursor_tracker_unit.sv -----
// Top level of the mouse packet cursor tracker: front end, packet queue,
// back end and result queue. Depends on mpct_pkg, mpct_front, mpct_back, mpct_queue.
//
//   channel   | direction | handshake           | payload
//   ----------+-----------+---------------------+---------------------------------
//   bytes     | in        | push / full         | data_byte
//   results   | out       | pop / empty         | overflow .. paste_request
//
// One byte is accepted per cycle while full is low; every third byte closes a packet.
// A packet's result reaches the result ports after it is registered in the packet queue;
// the back end then updates the cursor state and fills the result queue.
// rst (synchronous) clears byte position, buttons, cursor, selection and queues.
// The back end holds while the result queue is full; full is high while the last
// byte of a packet is due and the packet queue is full.
`default_nettype none

module mouse_packet_cursor_tracker_unit #(
  parameter int GRID_COLS = mpct_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = mpct_pkg::GRID_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  data_byte,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output logic        overflow,
  output logic        left_down,
  output logic        right_down,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [11:0] cell_address,
  output logic [1:0]  select_event,
  output logic [6:0]  anchor_col,
  output logic [4:0]  anchor_row,
  output logic [6:0]  corner_col,
  output logic [4:0]  corner_row,
  output logic        paste_request
);

  import mpct_pkg::*;

  pkt_t pkt_in;
  pkt_t pkt_head;
  logic pkt_push;
  logic pkt_full;
  logic pkt_empty;
  logic pkt_pop;
  res_t res_in;
  res_t res_head;
  logic res_push;
  logic res_full;

  mpct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .full      (full),
    .pkt_push  (pkt_push),
    .pkt       (pkt_in),
    .pkt_full  (pkt_full)
  );

  mpct_queue #(
    .WIDTH ($bits(pkt_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_pkt_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (pkt_push),
    .wdata (pkt_in),
    .full  (pkt_full),
    .pop   (pkt_pop),
    .rdata (pkt_head),
    .empty (pkt_empty)
  );

  mpct_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pkt_empty (pkt_empty),
    .pkt       (pkt_head),
    .pkt_pop   (pkt_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  mpct_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign overflow      = res_head.overflow;
  assign left_down     = res_head.left_down;
  assign right_down    = res_head.right_down;
  assign cursor_col    = res_head.cursor_col;
  assign cursor_row    = res_head.cursor_row;
  assign cell_address  = res_head.cell_address;
  assign select_event  = res_head.select_event;
  assign anchor_col    = res_head.anchor_col;
  assign anchor_row    = res_head.anchor_row;
  assign corner_col    = res_head.corner_col;
  assign corner_row    = res_head.corner_row;
  assign paste_request = res_head.paste_request;

endmodule

`default_nettype wire

// ----- hw/rtl/mpct_checker.sv -----
// Port-level checks for the mouse packet cursor tracker, bound to its top level.
// Depends on mpct_pkg and mouse_packet_cursor_tracker_unit.
`default_nettype none

module mpct_checker (
  input logic        clk,
  input logic        rst,
  input logic        pop,
  input logic        empty,
  input logic        overflow,
  input logic        left_down,
  input logic [11:0] cell_address,
  input logic [1:0]  select_event,
  input logic [6:0]  anchor_col,
  input logic [4:0]  anchor_row,
  input logic [6:0]  corner_col,
  input logic [4:0]  corner_row,
  input logic        paste_request
);

  import mpct_pkg::*;

  a_reset_empty : assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_overflow_no_paste : assert property (@(posedge clk) disable iff (rst)
    (!empty && overflow) |-> !paste_request)
    else $error("paste requested on overflow packet");

  a_none_zero_corners : assert property (@(posedge clk) disable iff (rst)
    (!empty && select_event == SEL_NONE) |->
      (anchor_col == '0 && anchor_row == '0 && corner_col == '0 && corner_row == '0))
    else $error("corners set without selection event");

  a_press_corner : assert property (@(posedge clk) disable iff (rst)
    (!empty && select_event == SEL_PRESS) |->
      (left_down && corner_col == anchor_col && corner_row == anchor_row))
    else $error("press transaction with corner apart from anchor");

  a_hold_result : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=>
      (!empty && $stable(cell_address) && $stable(select_event)))
    else $error("waiting result transaction changed");

endmodule

bind mouse_packet_cursor_tracker_unit mpct_checker u_mpct_checker (.*);

`default_nettype wire

// ----- dv/mpct_report_checker.sv -----
// Checker for the mouse packet cursor tracker: watches the byte and report
// channels, predicts every packet report and compares it field by field.
// Depends on mpct_pkg for the report layout, grid size and status bit positions.
`timescale 1ns / 1ps

module mpct_report_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  data_byte,
  input  logic        full,
  input  logic        pop,
  input  logic        empty,
  input  logic        overflow,
  input  logic        left_down,
  input  logic        right_down,
  input  logic [6:0]  cursor_col,
  input  logic [4:0]  cursor_row,
  input  logic [11:0] cell_address,
  input  logic [1:0]  select_event,
  input  logic [6:0]  anchor_col,
  input  logic [4:0]  anchor_row,
  input  logic [6:0]  corner_col,
  input  logic [4:0]  corner_row,
  input  logic        paste_request,
  output int          mismatches,
  output int          pending,
  output int          reports_checked
);

  import mpct_pkg::*;

  localparam int COLS = GRID_COLS_DEF;
  localparam int ROWS = GRID_ROWS_DEF;

  logic [1:0]            packet_phase;
  logic [7:0]            held_status;
  logic [7:0]            held_xdelta;
  logic                  left_btn;
  logic                  right_btn;
  logic [COL_PORT_W-1:0] cur_col;
  logic [ROW_PORT_W-1:0] cur_row;
  logic [COL_PORT_W-1:0] sel_start_col;
  logic [ROW_PORT_W-1:0] sel_start_row;
  logic [COL_PORT_W-1:0] sel_end_col;
  logic [ROW_PORT_W-1:0] sel_end_row;
  res_t                  expected_reports[$];

  task automatic decode_mouse_byte(input logic [7:0] b);
    res_t rpt;
    logic was_left;
    logic was_right;
    int   col;
    int   row;
    case (packet_phase)
      2'd1: begin
        held_xdelta  = b;
        packet_phase = 2'd2;
      end
      2'd2: begin
        packet_phase = 2'd0;
        was_left     = left_btn;
        was_right    = right_btn;
        rpt          = '0;
        rpt.overflow = held_status[ST_YOVF] | held_status[ST_XOVF];
        if (!rpt.overflow) begin
          right_btn = held_status[ST_RIGHT];
          left_btn  = held_status[ST_LEFT];
          col = int'(cur_col);
          row = int'(cur_row);
          if (held_xdelta != 8'd0) col = held_status[ST_XSIGN] ? col - 1 : col + 1;
          if (b != 8'd0) row = held_status[ST_YSIGN] ? row + 1 : row - 1;
          if (col < 0) col = 0;
          if (col > COLS - 1) col = COLS - 1;
          if (row < 0) row = 0;
          if (row > ROWS - 1) row = ROWS - 1;
          cur_col = col[COL_PORT_W-1:0];
          cur_row = row[ROW_PORT_W-1:0];
        end
        if (left_btn && !was_left) begin
          sel_start_col    = cur_col;
          sel_start_row    = cur_row;
          rpt.select_event = SEL_PRESS;
          rpt.anchor_col   = sel_start_col;
          rpt.anchor_row   = sel_start_row;
          rpt.corner_col   = sel_start_col;
          rpt.corner_row   = sel_start_row;
        end else if (left_btn || was_left) begin
          sel_end_col      = cur_col;
          sel_end_row      = cur_row;
          rpt.select_event = left_btn ? SEL_DRAG : SEL_RELEASE;
          rpt.anchor_col   = sel_start_col;
          rpt.anchor_row   = sel_start_row;
          rpt.corner_col   = sel_end_col;
          rpt.corner_row   = sel_end_row;
        end
        rpt.left_down     = left_btn;
        rpt.right_down    = right_btn;
        rpt.cursor_col    = cur_col;
        rpt.cursor_row    = cur_row;
        rpt.paste_request = right_btn & !was_right;
        rpt.cell_address  = ADDR_PORT_W'((int'(cur_col) + int'(cur_row) * COLS) * 2 + 1);
        expected_reports.push_back(rpt);
      end
      default: begin
        held_status  = b;
        packet_phase = 2'd1;
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      packet_phase  = 2'd0;
      held_status   = '0;
      held_xdelta   = '0;
      left_btn      = 1'b0;
      right_btn     = 1'b0;
      cur_col       = '0;
      cur_row       = '0;
      sel_start_col = '0;
      sel_start_row = '0;
      sel_end_col   = '0;
      sel_end_row   = '0;
      expected_reports.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report popped with none expected, actual col %0d row %0d",
                   $time, cursor_col, cursor_row);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("overflow", int'(want.overflow), int'(overflow));
          check_field("left_down", int'(want.left_down), int'(left_down));
          check_field("right_down", int'(want.right_down), int'(right_down));
          check_field("cursor_col", int'(want.cursor_col), int'(cursor_col));
          check_field("cursor_row", int'(want.cursor_row), int'(cursor_row));
          check_field("cell_address", int'(want.cell_address), int'(cell_address));
          check_field("select_event", int'(want.select_event), int'(select_event));
          check_field("anchor_col", int'(want.anchor_col), int'(anchor_col));
          check_field("anchor_row", int'(want.anchor_row), int'(anchor_row));
          check_field("corner_col", int'(want.corner_col), int'(corner_col));
          check_field("corner_row", int'(want.corner_row), int'(corner_row));
          check_field("paste_request", int'(want.paste_request), int'(paste_request));
          reports_checked++;
        end
      end
      if (push && !full) decode_mouse_byte(data_byte);
    end
    pending <= expected_reports.size();
  end

endmodule

// ----- dv/tb_mouse_packet_cursor_tracker_unit.sv -----
// Testbench top for the mouse packet cursor tracker: drives directed and random
// mouse packets under several idle/stall mixes and gives the verdict.
// Depends on mouse_packet_cursor_tracker_unit and mpct_report_checker.
`timescale 1ns / 1ps

module tb_mouse_packet_cursor_tracker_unit;

  localparam int PHASES = 4;
  localparam int PACKETS_PER_PHASE = 58;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        full;
  logic        pop = 1'b0;
  logic        empty;
  logic        overflow;
  logic        left_down;
  logic        right_down;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [11:0] cell_address;
  logic [1:0]  select_event;
  logic [6:0]  anchor_col;
  logic [4:0]  anchor_row;
  logic [6:0]  corner_col;
  logic [4:0]  corner_row;
  logic        paste_request;
  int          mismatches;
  int          pending;
  int          reports_checked;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   bytes_sent = 0;
  int   packet_no = 0;
  logic left_hold = 1'b0;
  logic right_hold = 1'b0;

  // status, x delta, y delta per packet: clamp at origin, steps, press, drag,
  // overflow while held, release, paste, overflow with right held
  logic [7:0] directed_bytes[24] = '{
    8'h18, 8'hFF, 8'h80,
    8'h28, 8'h01, 8'h01,
    8'h09, 8'h7F, 8'h00,
    8'h29, 8'h00, 8'hFF,
    8'h89, 8'h10, 8'h10,
    8'h08, 8'h02, 8'h00,
    8'h0A, 8'h00, 8'h00,
    8'h4A, 8'h01, 8'h01
  };

  int send_idle_by_phase[PHASES]  = '{0, 80, 0, 9};
  int recv_stall_by_phase[PHASES] = '{0, 0, 80, 9};

  mouse_packet_cursor_tracker_unit dut (.*);
  mpct_report_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) pop <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input bit noise);
    logic [7:0] st;
    logic [7:0] dx;
    logic [7:0] dy;
    bit         drift_left;
    bit         drift_up;
    if (noise) begin
      st = 8'($urandom);
      dx = 8'($urandom);
      dy = 8'($urandom);
    end else begin
      // sweep the cursor across the whole grid and back
      drift_left = ((packet_no / 110) % 2) != 0;
      drift_up   = ((packet_no / 40) % 2) != 0;
      if ($urandom_range(3) == 0) left_hold = !left_hold;
      if ($urandom_range(3) == 0) right_hold = !right_hold;
      st = 8'h08;
      st[2] = 1'($urandom_range(1));
      st[mpct_pkg::ST_LEFT]  = left_hold;
      st[mpct_pkg::ST_RIGHT] = right_hold;
      st[mpct_pkg::ST_XSIGN] = drift_left ? ($urandom_range(19) != 0)
                                          : ($urandom_range(19) == 0);
      st[mpct_pkg::ST_YSIGN] = drift_up ? ($urandom_range(19) == 0)
                                        : ($urandom_range(19) != 0);
      if ($urandom_range(15) == 0) st[7:6] = 2'($urandom_range(1, 3));
      dx = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      dy = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    end
    send_byte(st);
    send_byte(dx);
    send_byte(dy);
    packet_no++;
  endtask

  task automatic drain_reports();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    drain_reports();
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      repeat (PACKETS_PER_PHASE) send_packet($urandom_range(4) == 0);
      drain_reports();
    end
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    $display("covered %0d mouse bytes in %0d handshake mixes, %0d packet reports checked",
             bytes_sent, PHASES + 1, reports_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
